>>> rtl/sync_frame_deframer_crc16_core_assert.svh
// Assertion macros for the framed packet receiver core.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef SYNC_FRAME_DEFRAMER_CRC16_CORE_ASSERT_SVH
`define SYNC_FRAME_DEFRAMER_CRC16_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define SFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Check that a condition in one cycle implies another in the next cycle
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFD_ASSERT(lbl, prop, msg)
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/sfd_pkg.sv
// Shared constants and types for the framed packet receiver core.
// No dependencies; used by sfd_crc_unit and the top level.
package sfd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int CRC_W       = 16;
    localparam int STEP_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_TOP   = 16'h8000;
    localparam logic [STEP_W-1:0] CRC_STEPS = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT  = 3'd4;

    // Frame parser phase
    typedef enum logic [8:0] {
        PH_HEAD0 = 9'b000000001,
        PH_HEAD1 = 9'b000000010,
        PH_ID    = 9'b000000100,
        PH_LEN   = 9'b000001000,
        PH_DATA  = 9'b000010000,
        PH_CRCL  = 9'b000100000,
        PH_CRCH  = 9'b001000000,
        PH_TAIL0 = 9'b010000000,
        PH_TAIL1 = 9'b100000000
    } t_phase;

    // Sequencer state
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CRC  = 4'b0010,
        S_RD   = 4'b0100,
        S_LOAD = 4'b1000
    } t_seq;

    typedef struct packed {
        logic              start;
        logic              init;
        logic [BYTE_W-1:0] data;
    } t_crc_ctrl;

    typedef struct packed {
        logic             busy;
        logic [CRC_W-1:0] crc;
    } t_crc_stat;

endpackage

>>> rtl/sync_frame_deframer_crc16_core.sv
// Framed packet receiver with CRC-16/CCITT-FALSE check, top level.
// Depends on sfd_pkg, sfd_crc_unit and the assertion macro header.
//
// Takes one received word per accepted input and parses frames of the form
// header, header, id, length, payload, CRC low, CRC high, tail, tail. Header,
// CRC and tail words are taken without a stall, and so is a length word above
// the limit. The id, an accepted length and each payload word start the
// bit-serial CRC unit, which shifts one bit per cycle; the input stalls until
// it is done. A good frame is delivered from the 32-entry payload memory one
// result word at a time (memory read, then output register load, which waits
// while the output is stalled); the input stalls during that run, and a
// zero-length frame gives a single result marked empty. The output register
// lets the next frame start while the final result still waits to be taken.
`include "sync_frame_deframer_crc16_core_assert.svh"
module sync_frame_deframer_crc16_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sfd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sfd_pkg::BYTE_W-1:0]     o_frame_tag,
    output logic [sfd_pkg::LEN_W-1:0]      o_payload_length,
    output logic [sfd_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic [sfd_pkg::ADDR_W-1:0]     o_byte_position,
    output logic                           o_has_data,
    output logic                           o_last
);
    import sfd_pkg::*;

    // Configuration registers
    logic [BYTE_W-1:0] r_header_first;
    logic [BYTE_W-1:0] r_header_second;
    logic [BYTE_W-1:0] r_tail_first;
    logic [BYTE_W-1:0] r_tail_second;
    logic [LEN_W-1:0]  r_length_limit;

    // Parser and sequencer state
    t_phase            r_phase, n_phase;
    t_seq              r_seq, n_seq;
    logic [BYTE_W-1:0] r_id_byte, n_id_byte;
    logic [LEN_W-1:0]  r_length, n_length;
    logic [LEN_W-1:0]  r_taken, n_taken;
    logic [CRC_W-1:0]  r_rx_crc, n_rx_crc;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic              r_empty, n_empty;
    logic              r_o_valid, n_o_valid;

    // Payload memory
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rd_data;

    // Output payload registers
    logic [BYTE_W-1:0] r_o_tag;
    logic [LEN_W-1:0]  r_o_len;
    logic [BYTE_W-1:0] r_o_byte;
    logic [ADDR_W-1:0] r_o_pos;
    logic              r_o_has;
    logic              r_o_last;

    logic              in_acc;
    logic              out_free;
    logic              mem_we;
    logic              load_out;
    logic              ld_last;
    logic [LEN_W-1:0]  eff_limit;
    t_crc_ctrl         crc_ctrl;
    t_crc_stat         crc_stat;

    sfd_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_stat  (crc_stat)
    );

    assign in_acc   = i_valid && (r_seq == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign ld_last  = r_empty || ((LEN_W'(r_rd_idx) + LEN_W'(1)) == r_length);
    assign eff_limit = (r_length_limit > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                              : r_length_limit;

    // Parse accepted words and run the sequencer
    always_comb begin
        n_phase    = r_phase;
        n_seq      = r_seq;
        n_id_byte  = r_id_byte;
        n_length   = r_length;
        n_taken    = r_taken;
        n_rx_crc   = r_rx_crc;
        n_rd_idx   = r_rd_idx;
        n_empty    = r_empty;
        mem_we     = 1'b0;
        load_out   = 1'b0;
        crc_ctrl.start = 1'b0;
        crc_ctrl.init  = 1'b0;
        crc_ctrl.data  = i_rx_byte;

        unique case (r_seq)
            S_IDLE: begin
            end
            S_CRC: begin
                if (!crc_stat.busy) begin
                    n_seq = S_IDLE;
                end
            end
            S_RD: begin
                n_seq = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (ld_last) begin
                        n_seq = S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + ADDR_W'(1);
                        n_seq    = S_RD;
                    end
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase

        if (in_acc) begin
            unique case (r_phase)
                PH_HEAD0: begin
                    if (i_rx_byte == r_header_first) begin
                        n_phase = PH_HEAD1;
                        n_taken = '0;
                    end
                end
                PH_HEAD1: begin
                    n_phase = (i_rx_byte == r_header_second) ? PH_ID : PH_HEAD0;
                end
                PH_ID: begin
                    n_id_byte      = i_rx_byte;
                    crc_ctrl.start = 1'b1;
                    crc_ctrl.init  = 1'b1;
                    n_seq          = S_CRC;
                    n_phase        = PH_LEN;
                end
                PH_LEN: begin
                    if (i_rx_byte > {{(BYTE_W - LEN_W){1'b0}}, eff_limit}) begin
                        n_phase = PH_HEAD0;
                    end else begin
                        n_length       = i_rx_byte[LEN_W-1:0];
                        crc_ctrl.start = 1'b1;
                        n_seq          = S_CRC;
                        n_phase        = (i_rx_byte == '0) ? PH_CRCL : PH_DATA;
                    end
                end
                PH_DATA: begin
                    mem_we         = 1'b1;
                    n_taken        = r_taken + LEN_W'(1);
                    crc_ctrl.start = 1'b1;
                    n_seq          = S_CRC;
                    if ((r_taken + LEN_W'(1)) >= r_length) begin
                        n_phase = PH_CRCL;
                    end
                end
                PH_CRCL: begin
                    n_rx_crc = {{(CRC_W - BYTE_W){1'b0}}, i_rx_byte};
                    n_phase  = PH_CRCH;
                end
                PH_CRCH: begin
                    n_rx_crc = {i_rx_byte, r_rx_crc[BYTE_W-1:0]};
                    n_phase  = PH_TAIL0;
                end
                PH_TAIL0: begin
                    n_phase = (i_rx_byte == r_tail_first) ? PH_TAIL1 : PH_HEAD0;
                end
                PH_TAIL1: begin
                    // Start the result run on a good frame, drop it otherwise
                    if (i_rx_byte == r_tail_second && crc_stat.crc == r_rx_crc) begin
                        n_rd_idx = '0;
                        n_empty  = (r_length == '0);
                        n_seq    = (r_length == '0) ? S_LOAD : S_RD;
                    end
                    n_phase = PH_HEAD0;
                    n_taken = '0;
                end
                default: begin
                    n_phase = PH_HEAD0;
                    n_taken = '0;
                end
            endcase
        end

        // Drop the output word once taken unless a new one replaces it
        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD0;
            r_seq      <= S_IDLE;
            r_id_byte  <= '0;
            r_length   <= '0;
            r_taken    <= '0;
            r_rx_crc   <= '0;
            r_rd_idx   <= '0;
            r_empty    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_seq      <= n_seq;
            r_id_byte  <= n_id_byte;
            r_length   <= n_length;
            r_taken    <= n_taken;
            r_rx_crc   <= n_rx_crc;
            r_rd_idx   <= n_rd_idx;
            r_empty    <= n_empty;
            r_o_valid  <= n_o_valid;
        end
    end

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= 8'hAA;
            r_header_second <= 8'h55;
            r_tail_first    <= 8'h55;
            r_tail_second   <= 8'hAA;
            r_length_limit  <= LEN_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                CFG_TAIL_FIRST:    r_tail_first    <= i_cfg_data;
                CFG_TAIL_SECOND:   r_tail_second   <= i_cfg_data;
                CFG_LENGTH_LIMIT:  r_length_limit  <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Payload memory: write while parsing, registered read for the run
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_taken[ADDR_W-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_rd_idx];
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_tag  <= r_id_byte;
            r_o_len  <= r_empty ? '0 : r_length;
            r_o_byte <= r_empty ? '0 : r_rd_data;
            r_o_pos  <= r_empty ? '0 : r_rd_idx;
            r_o_has  <= !r_empty;
            r_o_last <= ld_last;
        end
    end

    assign o_stall          = (r_seq != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_frame_tag      = r_o_tag;
    assign o_payload_length = r_o_len;
    assign o_payload_byte   = r_o_byte;
    assign o_byte_position  = r_o_pos;
    assign o_has_data       = r_o_has;
    assign o_last           = r_o_last;

    // No word is taken while the CRC unit is still shifting
    `SFD_ASSERT(a_no_accept_busy, !(in_acc && crc_stat.busy), "word accepted while CRC busy")
    // An empty-frame result is alone and carries zeros
    `SFD_ASSERT(a_empty_result,
        !(o_valid && !o_has_data) || (o_last && o_payload_byte == '0 && o_payload_length == '0),
        "bad empty result")
    // Byte positions stay inside the frame length
    `SFD_ASSERT(a_pos_in_range,
        !(o_valid && o_has_data) || (LEN_W'(o_byte_position) < o_payload_length),
        "position out of range")
    // A result load leaves a valid word in the output register
    `SFD_ASSERT_NEXT(a_load_valid, load_out, o_valid, "loaded word not valid")

endmodule

>>> rtl/sfd_crc_unit.sv
// Bit-serial CRC-16 unit (poly 0x1021, MSB first): one bit per cycle.
// Depends on sfd_pkg for widths, constants and the control/status structs.
module sfd_crc_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfd_pkg::t_crc_ctrl i_ctrl,
    output sfd_pkg::t_crc_stat o_stat
);
    import sfd_pkg::*;

    logic [CRC_W-1:0]  r_crc;
    logic [STEP_W-1:0] r_bits;
    logic [CRC_W-1:0]  base;
    logic [CRC_W-1:0]  feed;
    logic [CRC_W-1:0]  step;

    // Fold the new byte into the high half, then shift one bit per cycle
    always_comb begin
        base = i_ctrl.init ? CRC_INIT : r_crc;
        feed = base ^ {i_ctrl.data, {(CRC_W - BYTE_W){1'b0}}};
        if ((r_crc & CRC_TOP) != '0) begin
            step = (r_crc << 1) ^ CRC_POLY;
        end else begin
            step = r_crc << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_bits <= '0;
        end else if (i_ctrl.start) begin
            r_crc  <= feed;
            r_bits <= CRC_STEPS;
        end else if (r_bits != '0) begin
            r_crc  <= step;
            r_bits <= r_bits - STEP_W'(1);
        end
    end

    assign o_stat.busy = (r_bits != '0);
    assign o_stat.crc  = r_crc;

endmodule

>>> dv/sync_frame_deframer_crc16_core_test.sv
// Self-checking testbench for sync_frame_deframer_crc16_core.
// Depends on sfd_pkg and the core; predicts the payload words of each good frame
// from a behavioral frame parser and checks them against the output channel.
module sync_frame_deframer_crc16_core_test;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] tag;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
        logic [ADDR_W-1:0] pos;
        logic              has_data;
        logic              last;
    } t_frame_word;

    typedef enum int {
        FLAW_NONE,
        FLAW_HEAD1,
        FLAW_LONG,
        FLAW_CRC,
        FLAW_TAIL0,
        FLAW_TAIL1
    } t_frame_flaw;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_rx_byte;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [BYTE_W-1:0]     o_frame_tag;
    logic [LEN_W-1:0]      o_payload_length;
    logic [BYTE_W-1:0]     o_payload_byte;
    logic [ADDR_W-1:0]     o_byte_position;
    logic                  o_has_data;
    logic                  o_last;

    // Register copies
    logic [7:0] cfg_hdr_first;
    logic [7:0] cfg_hdr_second;
    logic [7:0] cfg_tail_first;
    logic [7:0] cfg_tail_second;
    logic [5:0] cfg_len_limit;

    // Parser state of the predictor
    t_phase            rx_phase;
    logic [7:0]        rx_tag;
    logic [5:0]        frame_len;
    logic [5:0]        taken_cnt;
    logic [7:0]        payload_mem [MAX_PAYLOAD];
    logic [CRC_W-1:0]  run_crc;
    logic [CRC_W-1:0]  got_crc;

    t_frame_word expected_words[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int rx_bytes_sent = 0;
    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_left     = 0;

    sync_frame_deframer_crc16_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_tag      (o_frame_tag),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_byte_position  (o_byte_position),
        .o_has_data       (o_has_data),
        .o_last           (o_last)
    );

    always #4 i_clk = ~i_clk;

    // One CRC-16/CCITT-FALSE byte update, MSB first
    function automatic logic [CRC_W-1:0] crc16_feed(logic [CRC_W-1:0] crc, logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic int length_cap();
        return (cfg_len_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_len_limit);
    endfunction

    function automatic void reset_parser_model();
        cfg_hdr_first   = 8'hAA;
        cfg_hdr_second  = 8'h55;
        cfg_tail_first  = 8'h55;
        cfg_tail_second = 8'hAA;
        cfg_len_limit   = 6'd32;
        rx_phase        = PH_HEAD0;
        rx_tag          = '0;
        frame_len       = '0;
        taken_cnt       = '0;
        run_crc         = CRC_INIT;
        got_crc         = '0;
        foreach (payload_mem[k]) payload_mem[k] = '0;
    endfunction

    // Advance the parser by one received word and queue the payload of a good frame
    function automatic void parse_rx_byte(logic [7:0] b);
        t_frame_word w;
        case (rx_phase)
            PH_HEAD0: begin
                if (b == cfg_hdr_first) begin
                    rx_phase  = PH_HEAD1;
                    taken_cnt = '0;
                end
            end
            PH_HEAD1: begin
                if (b == cfg_hdr_second) begin
                    rx_phase = PH_ID;
                    run_crc  = CRC_INIT;
                end else begin
                    rx_phase = PH_HEAD0;
                end
            end
            PH_ID: begin
                rx_tag   = b;
                run_crc  = crc16_feed(CRC_INIT, b);
                rx_phase = PH_LEN;
            end
            PH_LEN: begin
                if (int'(b) > length_cap()) begin
                    rx_phase = PH_HEAD0;
                end else begin
                    frame_len = b[5:0];
                    run_crc   = crc16_feed(run_crc, b);
                    rx_phase  = (b == 8'd0) ? PH_CRCL : PH_DATA;
                end
            end
            PH_DATA: begin
                if (taken_cnt < frame_len && taken_cnt < MAX_PAYLOAD) begin
                    payload_mem[taken_cnt[ADDR_W-1:0]] = b;
                    taken_cnt = taken_cnt + 6'd1;
                    run_crc   = crc16_feed(run_crc, b);
                end
                if (taken_cnt >= frame_len || taken_cnt >= MAX_PAYLOAD) rx_phase = PH_CRCL;
            end
            PH_CRCL: begin
                got_crc  = {8'h00, b};
                rx_phase = PH_CRCH;
            end
            PH_CRCH: begin
                got_crc[15:8] = b;
                rx_phase      = PH_TAIL0;
            end
            PH_TAIL0: begin
                rx_phase = (b == cfg_tail_first) ? PH_TAIL1 : PH_HEAD0;
            end
            PH_TAIL1: begin
                if (b == cfg_tail_second && run_crc == got_crc) begin
                    if (frame_len == 0) begin
                        w.tag      = rx_tag;
                        w.len      = '0;
                        w.data     = '0;
                        w.pos      = '0;
                        w.has_data = 1'b0;
                        w.last     = 1'b1;
                        expected_words.push_back(w);
                    end else begin
                        for (int k = 0; k < frame_len; k++) begin
                            w.tag      = rx_tag;
                            w.len      = frame_len;
                            w.data     = payload_mem[k];
                            w.pos      = k[ADDR_W-1:0];
                            w.has_data = 1'b1;
                            w.last     = (k + 1 == frame_len);
                            expected_words.push_back(w);
                        end
                    end
                end
                rx_phase  = PH_HEAD0;
                taken_cnt = '0;
            end
            default: begin
                rx_phase  = PH_HEAD0;
                taken_cnt = '0;
            end
        endcase
    endfunction

    // Track every accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) parse_rx_byte(i_rx_byte);
    end

    // Compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word: frame_tag %0h payload_byte %0h",
                       o_frame_tag, o_payload_byte);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_frame_tag !== want.tag) begin
                    $error("frame_tag: expected %0h, got %0h", want.tag, o_frame_tag);
                    error_count++;
                end
                if (o_payload_length !== want.len) begin
                    $error("payload_length: expected %0d, got %0d", want.len, o_payload_length);
                    error_count++;
                end
                if (o_payload_byte !== want.data) begin
                    $error("payload_byte: expected %0h, got %0h", want.data, o_payload_byte);
                    error_count++;
                end
                if (o_byte_position !== want.pos) begin
                    $error("byte_position: expected %0d, got %0d", want.pos, o_byte_position);
                    error_count++;
                end
                if (o_has_data !== want.has_data) begin
                    $error("has_data: expected %0b, got %0b", want.has_data, o_has_data);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Receiver: hold off for a requested stretch, else stall at random
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one word, idling at random first, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rx_bytes_sent++;
    endtask

    // Build one frame with the current sync and tail words, optionally damaged
    task automatic send_frame(input logic [7:0] id, input int len, input t_frame_flaw flaw,
                              input int fill = -1);
        logic [7:0]       bytes_q[$];
        logic [7:0]       data_b;
        logic [CRC_W-1:0] crc;
        int               cap;
        cap = length_cap();
        bytes_q.push_back(cfg_hdr_first);
        // second sync word wrong; repeating the first one must not resync
        if (flaw == FLAW_HEAD1)
            bytes_q.push_back((cfg_hdr_first == cfg_hdr_second) ? ~cfg_hdr_second
                                                                 : cfg_hdr_first);
        bytes_q.push_back(cfg_hdr_second);
        bytes_q.push_back(id);
        if (flaw == FLAW_LONG) begin
            data_b = $urandom_range(1) ? 8'(cap + 1) : 8'($urandom_range(255, cap + 1));
            bytes_q.push_back(data_b);
        end else begin
            crc = crc16_feed(CRC_INIT, id);
            bytes_q.push_back(8'(len));
            crc = crc16_feed(crc, 8'(len));
            for (int k = 0; k < len; k++) begin
                data_b = (fill < 0) ? 8'($urandom) : 8'(fill);
                bytes_q.push_back(data_b);
                crc = crc16_feed(crc, data_b);
            end
            if (flaw == FLAW_CRC) crc = crc ^ (16'h1 << $urandom_range(15));
            bytes_q.push_back(crc[7:0]);
            bytes_q.push_back(crc[15:8]);
            data_b = cfg_tail_first;
            if (flaw == FLAW_TAIL0) data_b = data_b ^ 8'($urandom_range(255, 1));
            bytes_q.push_back(data_b);
            data_b = cfg_tail_second;
            if (flaw == FLAW_TAIL1) data_b = data_b ^ 8'($urandom_range(255, 1));
            bytes_q.push_back(data_b);
        end
        foreach (bytes_q[k]) send_byte(bytes_q[k]);
    endtask

    // Drop valid, wait for every expected word, then let the core go quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_HEADER_FIRST:  cfg_hdr_first   = val;
            CFG_HEADER_SECOND: cfg_hdr_second  = val;
            CFG_TAIL_FIRST:    cfg_tail_first  = val;
            CFG_TAIL_SECOND:   cfg_tail_second = val;
            CFG_LENGTH_LIMIT:  cfg_len_limit   = val[5:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] h1, input logic [7:0] h2,
                                input logic [7:0] t1, input logic [7:0] t2,
                                input logic [7:0] lim);
        write_reg(CFG_HEADER_FIRST, h1);
        write_reg(CFG_HEADER_SECOND, h2);
        write_reg(CFG_TAIL_FIRST, t1);
        write_reg(CFG_TAIL_SECOND, t2);
        write_reg(CFG_LENGTH_LIMIT, lim);
        i_cfg_we <= 1'b0;
    endtask

    // Field extremes with the reset register values
    task automatic test_frame_extremes();
        send_frame(8'h00, 0, FLAW_NONE);
        send_frame(8'hFF, MAX_PAYLOAD, FLAW_NONE, 8'hFF);
    endtask

    // Each way a frame is dropped, then a good one to show recovery
    task automatic test_frame_errors();
        send_frame(8'($urandom), 0, FLAW_HEAD1);
        send_frame(8'($urandom), 0, FLAW_LONG);
        send_frame(8'($urandom), 0, FLAW_CRC);
        send_frame(8'($urandom), 0, FLAW_TAIL0);
        send_frame(8'($urandom), 0, FLAW_TAIL1);
        send_frame(8'($urandom), 1, FLAW_NONE);
    endtask

    // Register extremes, masking of the limit and writes to unused indexes
    task automatic test_config_regs();
        settle();
        program_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_frame(8'($urandom), 0, FLAW_NONE);
        send_frame(8'($urandom), 0, FLAW_LONG);
        settle();
        // limit above the payload store clamps to its size
        program_regs(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
        send_byte(cfg_hdr_first);
        send_byte(cfg_hdr_second);
        send_byte(8'($urandom));
        send_byte(8'(MAX_PAYLOAD + 1));
        settle();
        // upper data bits of the limit are dropped
        program_regs(8'h3C, 8'hC3, 8'h96, 8'h69, 8'hC3);
        send_frame(8'($urandom), 0, FLAW_LONG);
        settle();
        for (int k = CFG_LENGTH_LIMIT + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), 8'($urandom));
        i_cfg_we <= 1'b0;
        send_frame(8'($urandom), 3, FLAW_NONE);
        settle();
        program_regs(8'hAA, 8'h55, 8'h55, 8'hAA, 8'd32);
    endtask

    // Long receiver hold while frames keep coming, then a full drain
    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        settle();
        hold_left = 300;
        repeat (2) send_frame(8'($urandom), 2, FLAW_NONE);
        settle();
    endtask

    // Mostly good frames with random content, some damaged frames and noise
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_bytes);
        int stop_at;
        int pick;
        int cap;
        int len;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        settle();
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom_range(63, 4)));
        stop_at = rx_bytes_sent + n_bytes;
        while (rx_bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            cap  = length_cap();
            len  = ($urandom_range(9) < 8) ? $urandom_range((cap < 8) ? cap : 8)
                                          : $urandom_range(cap);
            if (pick < 70)
                send_frame(8'($urandom), len, FLAW_NONE);
            else if (pick < 90)
                send_frame(8'($urandom), len,
                           t_frame_flaw'($urandom_range(FLAW_TAIL1, FLAW_HEAD1)));
            else
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
        end
        settle();
    endtask

    initial begin
        reset_parser_model();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_rx_byte   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 35;
        rcv_idle_pct = 76;
        test_frame_extremes();
        test_frame_errors();
        test_config_regs();
        test_random_traffic(35, 76, 8);
        test_random_traffic(76, 35, 8);
        test_random_traffic(0, 0, 8);
        test_backpressure();

        settle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
